[rtl/rvd_pkg.sv]
// Shared types and constants for the varint run-length decoder.
// No dependencies; imported by rvd_run_check and rle_varint_run_decoder_unit.
package rvd_pkg;

    // Decoder phase: which kind of byte the stream expects next
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_RAW      = 3'd1,
        PH_PAIR_VAL = 3'd2,
        PH_PAIR_CNT = 3'd3,
        PH_ALT_V0   = 3'd4,
        PH_ALT_V1   = 3'd5,
        PH_ALT_CNT  = 3'd6
    } phase_t;

    // Stream header codes
    localparam logic [7:0] HDR_RAW    = 8'd0;
    localparam logic [7:0] HDR_PAIR   = 8'd1;
    localparam logic [7:0] HDR_ALT    = 8'd2;
    localparam logic [7:0] HDR_ABSENT = 8'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADHEAD = 2'd1;
    localparam logic [1:0] ST_OVER    = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    // Varint byte layout
    localparam int MORE_BIT   = 7;
    localparam int GROUP_BITS = 7;

    // Register addresses (byte addresses on the configuration port)
    localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;

    // Outcome of checking one run against the remaining entry count
    typedef struct packed {
        logic over;   // run goes past the configured count
        logic exact;  // run ends exactly on the configured count
    } run_chk_t;

endpackage

[rtl/rle_varint_run_decoder_unit.sv]
// Top level of the varint run-length decoder: byte stream in, runs out.
// Depends on rvd_pkg and rvd_run_check.
//
// Usage:
// The slave stream takes one compressed byte per transaction (s_axis_tdata).
// The first byte of a stream is a mode header: raw, value/varint pairs,
// alternating values with varint counts, or absent. Each completed run is
// sent on the master stream as value, start index and length in tdata, with
// the status code in tuser and tlast marking the final run of a stream
// (count covered, run past the count, unknown header or absent table).
// Raw, pair and alternating headers, value bytes and non-final varint bytes
// produce no transaction. The user writes the entry count over the APB port
// at address 0 only while idle; the block itself does not enforce this.
// An accepted byte goes through the input register, then the result register.
// Throughput is one byte per cycle while the receiver keeps up; the per-byte
// state update is a 32-bit subtract, compare and add.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more byte before tready drops.
// Reset returns the decoder to expecting a header with position zero and
// sets the entry count to one.
module rle_varint_run_decoder_unit
    import rvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Compressed byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    // Decoded runs
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [7:0] run_value, [39:8] run_start,
                                        // [72:40] run_length, [79:73] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // finished
);

    logic [31:0] entry_count_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        fire;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] pos_reg, pos_next;
    logic [7:0]  pend_reg, pend_next;
    logic [7:0]  alt0_reg, alt0_next;
    logic [7:0]  alt1_reg, alt1_next;
    logic        toggle_reg, toggle_next;

    logic [31:0] acc_full;
    logic [31:0] count_m1;
    run_chk_t    chk;
    logic [32:0] run_length;
    logic [31:0] pos_after;

    logic        emit;
    logic [7:0]  emit_value;

    logic        res_valid;
    logic [7:0]  res_value;
    logic [31:0] res_start;
    logic [32:0] res_length;
    logic [1:0]  res_status;
    logic        res_fin;

    logic        out_valid_reg;
    logic [7:0]  out_value_reg;
    logic [31:0] out_start_reg;
    logic [32:0] out_length_reg;
    logic [1:0]  out_status_reg;
    logic        out_fin_reg;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ENTRY_COUNT) ? entry_count_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= 32'd1;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_ENTRY_COUNT))
        begin
            entry_count_reg <= pwdata;
        end
    end

    // Handshake: the byte in the input register is processed when the
    // result register is free or being emptied this cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Varint accumulation and run check
    assign acc_full = {acc_reg[31-GROUP_BITS:0], in_byte_reg[GROUP_BITS-1:0]};
    assign count_m1 = (phase_reg == PH_RAW) ? 32'd0 : acc_full;

    rvd_run_check u_run_check (
        .entry_count    (entry_count_reg),
        .position       (pos_reg),
        .count_m1       (count_m1),
        .chk            (chk),
        .run_length     (run_length),
        .position_after (pos_after)
    );

    // Result for the byte in the input register
    always_comb
    begin
        emit       = 1'b0;
        emit_value = in_byte_reg;
        res_valid  = 1'b0;
        res_value  = 8'd0;
        res_start  = 32'd0;
        res_length = 33'd0;
        res_status = ST_OK;
        res_fin    = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                case (in_byte_reg) inside
                    HDR_RAW, HDR_PAIR, HDR_ALT:
                        res_valid = 1'b0;
                    HDR_ABSENT:
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_ABSENT;
                        res_fin    = 1'b1;
                    end
                    default:
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_BADHEAD;
                        res_fin    = 1'b1;
                    end
                endcase
            end
            PH_RAW:
            begin
                emit       = 1'b1;
                emit_value = in_byte_reg;
            end
            PH_PAIR_CNT:
            begin
                if (!in_byte_reg[MORE_BIT])
                begin
                    emit       = 1'b1;
                    emit_value = pend_reg;
                end
            end
            PH_ALT_CNT:
            begin
                if (!in_byte_reg[MORE_BIT])
                begin
                    emit       = 1'b1;
                    emit_value = toggle_reg ? alt1_reg : alt0_reg;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // A completed run: report it, finishing the stream when the count is met or passed
        if (emit)
        begin
            res_valid  = 1'b1;
            res_value  = emit_value;
            res_start  = pos_reg;
            res_length = run_length;
            res_status = chk.over ? ST_OVER : ST_OK;
            res_fin    = chk.over || chk.exact;
        end
    end

    // Next state of the decoder for the byte in the input register
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        alt0_next   = alt0_reg;
        alt1_next   = alt1_reg;
        toggle_next = toggle_reg;

        unique case (phase_reg)
            PH_HEADER:
            begin
                acc_next = 32'd0;
                case (in_byte_reg)
                    HDR_RAW:    phase_next = PH_RAW;
                    HDR_PAIR:   phase_next = PH_PAIR_VAL;
                    HDR_ALT:
                    begin
                        toggle_next = 1'b0;
                        phase_next  = PH_ALT_V0;
                    end
                    default:    phase_next = PH_HEADER;
                endcase
            end
            PH_RAW:
            begin
                phase_next = PH_RAW;
            end
            PH_PAIR_VAL:
            begin
                pend_next  = in_byte_reg;
                phase_next = PH_PAIR_CNT;
            end
            PH_PAIR_CNT:
            begin
                if (in_byte_reg[MORE_BIT])
                begin
                    acc_next = acc_full;
                end
                else
                begin
                    acc_next   = 32'd0;
                    phase_next = PH_PAIR_VAL;
                end
            end
            PH_ALT_V0:
            begin
                alt0_next  = in_byte_reg;
                phase_next = PH_ALT_V1;
            end
            PH_ALT_V1:
            begin
                alt1_next  = in_byte_reg;
                phase_next = PH_ALT_CNT;
            end
            PH_ALT_CNT:
            begin
                if (in_byte_reg[MORE_BIT])
                begin
                    acc_next = acc_full;
                end
                else
                begin
                    acc_next    = 32'd0;
                    toggle_next = !toggle_reg;
                end
            end
            default:
            begin
                // Unused phase encoding: restart the stream
                phase_next = PH_HEADER;
                pos_next   = 32'd0;
                acc_next   = 32'd0;
            end
        endcase

        // A completed run moves the position on
        if (emit)
        begin
            pos_next = pos_after;
        end

        // Any final result returns the decoder to the header phase
        if (res_fin)
        begin
            phase_next = PH_HEADER;
            pos_next   = 32'd0;
            acc_next   = 32'd0;
        end
    end

    // Decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            acc_reg    <= 32'd0;
            pos_reg    <= 32'd0;
            pend_reg   <= 8'd0;
            toggle_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            toggle_reg <= toggle_next;
        end
    end

    // Alternate values are written before any read
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            alt0_reg <= alt0_next;
            alt1_reg <= alt1_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_value_reg  <= res_value;
            out_start_reg  <= res_start;
            out_length_reg <= res_length;
            out_status_reg <= res_status;
            out_fin_reg    <= res_fin;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_length_reg, out_start_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_fin_reg;

endmodule

[rtl/rvd_run_check.sv]
// Run bounds check: compares a run against the entries left to cover
// and works out the position after the run. Depends on rvd_pkg.
module rvd_run_check
    import rvd_pkg::*;
(
    input  logic [31:0] entry_count,
    input  logic [31:0] position,
    input  logic [31:0] count_m1,     // run length minus one
    output run_chk_t    chk,
    output logic [32:0] run_length,
    output logic [31:0] position_after
);

    logic        has_room;
    logic [31:0] remaining;

    // Entries still to be covered; zero once the position has reached the count
    assign has_room  = entry_count > position;
    assign remaining = has_room ? (entry_count - position) : 32'd0;

    // Length is count_m1 + 1, so length > remaining is count_m1 >= remaining
    assign run_length  = {1'b0, count_m1} + 33'd1;
    assign chk.over    = count_m1 >= remaining;
    assign chk.exact   = has_room && (run_length == {1'b0, remaining});

    assign position_after = position + count_m1 + 32'd1;

endmodule

[tb/tb_rle_varint_run_decoder_unit.sv]
// Self-checking testbench for rle_varint_run_decoder_unit: a directed table of
// stream bytes and register writes, then random byte streams under varied flow control.
// Depends on rvd_pkg and the RTL of the decoder unit; needs no other files.
module tb_rle_varint_run_decoder_unit;
    import rvd_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 4;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SEGMENT_BYTES    = 92;

    // Byte address of the unused register slot; writes there must be ignored
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    // One decoded run, as carried by a master-side transaction
    typedef struct packed {
        logic [7:0]  value;
        logic [31:0] start;
        logic [32:0] length;
        logic [1:0]  status;
        logic        finished;
    } run_t;

    // Kinds of row in the directed table
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_COUNT_WRITE,
        ROW_SPARE_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] word;      // stream byte in [7:0], or register value
        logic        typed;     // expected run is written out in the row
        run_t        run;
    } row_t;

    // Travels with each offered byte so that the acceptance side knows
    // whether a typed expectation replaces the decoded one
    typedef struct packed {
        logic typed;
        run_t run;
    } byte_tag_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] stream_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;         // [7:0] run_value, [39:8] run_start,
                                       // [72:40] run_length, [79:73] zero
    logic [1:0]  m_axis_tuser;         // [1:0] status
    logic        m_axis_tlast;

    // Decoder state as this bench tracks it
    phase_t      dec_phase = PH_HEADER;
    logic [1:0]  dec_mode = '0;
    logic [31:0] dec_acc = '0;
    logic [31:0] dec_pos = '0;
    logic [7:0]  dec_pending = '0;
    logic [7:0]  dec_alt [0:1];
    logic        dec_toggle = 1'b0;
    logic [31:0] entry_limit = 32'd1;

    run_t        pending_runs [$];
    byte_tag_t   offered_tags [$];
    row_t        plan [$];

    int          err_count = 0;
    int          bytes_sent = 0;
    int          runs_checked = 0;
    int          cfg_writes = 0;
    int          status_seen [0:3] = '{0, 0, 0, 0};
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_token = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    run_t        head_run;
    run_t        decoded_run;
    byte_tag_t   head_tag;

    rle_varint_run_decoder_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // Back to waiting for a header, with the position cleared.
    function automatic void rewind_stream();
        dec_phase = PH_HEADER;
        dec_pos   = '0;
        dec_acc   = '0;
    endfunction

    // Entries still to be covered; zero once the position has reached the count.
    function automatic logic [32:0] entries_left();
        if (entry_limit > dec_pos)
            return {1'b0, entry_limit} - {1'b0, dec_pos};
        return 33'd0;
    endfunction

    // Place one run against the remaining entries and advance the position.
    function automatic run_t place_run(input logic [7:0] value, input logic [32:0] len);
        logic [32:0] left;
        run_t        r;
        left       = entries_left();
        r.value    = value;
        r.start    = dec_pos;
        r.length   = len;
        r.status   = ST_OK;
        r.finished = 1'b0;
        if (len > left)
        begin
            r.status   = ST_OVER;
            r.finished = 1'b1;
            rewind_stream();
        end
        else if (len == left)
        begin
            r.finished = 1'b1;
            rewind_stream();
        end
        else
            dec_pos = dec_pos + len[31:0];
        return r;
    endfunction

    // Consume one stream byte; returns 1 when it completes a run.
    function automatic bit decode_byte(input logic [7:0] b, output run_t r);
        logic [31:0] acc_next;
        logic [32:0] len;
        r        = '0;
        acc_next = {dec_acc[31-GROUP_BITS:0], b[GROUP_BITS-1:0]};
        case (dec_phase)
            PH_HEADER:
            begin
                dec_acc = '0;
                if (b <= HDR_ABSENT)
                    dec_mode = b[1:0];
                if (b == HDR_RAW)
                    dec_phase = PH_RAW;
                else if (b == HDR_PAIR)
                    dec_phase = PH_PAIR_VAL;
                else if (b == HDR_ALT)
                begin
                    dec_toggle = 1'b0;
                    dec_phase  = PH_ALT_V0;
                end
                else
                begin
                    r.status   = (b == HDR_ABSENT) ? ST_ABSENT : ST_BADHEAD;
                    r.finished = 1'b1;
                    rewind_stream();
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_RAW:
            begin
                r = place_run(b, 33'd1);
                return 1'b1;
            end
            PH_PAIR_VAL:
            begin
                dec_pending = b;
                dec_phase   = PH_PAIR_CNT;
                return 1'b0;
            end
            PH_ALT_V0:
            begin
                dec_alt[0] = b;
                dec_phase  = PH_ALT_V1;
                return 1'b0;
            end
            PH_ALT_V1:
            begin
                dec_alt[1] = b;
                dec_phase  = PH_ALT_CNT;
                return 1'b0;
            end
            PH_PAIR_CNT, PH_ALT_CNT:
            begin
                if (b[MORE_BIT])
                begin
                    dec_acc = acc_next;
                    return 1'b0;
                end
                dec_acc = '0;
                len     = {1'b0, acc_next} + 33'd1;
                if (dec_phase == PH_PAIR_CNT)
                begin
                    dec_phase = PH_PAIR_VAL;
                    r = place_run(dec_pending, len);
                end
                else
                begin
                    r = place_run(dec_alt[dec_toggle], len);
                    dec_toggle = ~dec_toggle;
                end
                return 1'b1;
            end
            default:
                rewind_stream();
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // Every accepted byte updates the tracked state and may queue a run.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            head_tag = offered_tags.pop_front();
            if (decode_byte(s_axis_tdata, decoded_run) && !head_tag.typed)
                pending_runs.push_back(decoded_run);
            if (head_tag.typed)
                pending_runs.push_back(head_tag.run);
        end
    end

    // Every run transaction is checked against the oldest queued run.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_runs.size() == 0)
            begin
                $error("run transaction with none expected: tdata %h, tuser %0d, tlast %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end
            else
            begin
                head_run = pending_runs.pop_front();
                runs_checked++;
                status_seen[m_axis_tuser]++;
                if (m_axis_tdata[7:0] !== head_run.value)
                begin
                    $error("run_value: expected %0h, got %0h",
                           head_run.value, m_axis_tdata[7:0]);
                    err_count++;
                end
                if (m_axis_tdata[39:8] !== head_run.start)
                begin
                    $error("run_start: expected %0h, got %0h",
                           head_run.start, m_axis_tdata[39:8]);
                    err_count++;
                end
                if (m_axis_tdata[72:40] !== head_run.length)
                begin
                    $error("run_length: expected %0h, got %0h",
                           head_run.length, m_axis_tdata[72:40]);
                    err_count++;
                end
                if (m_axis_tdata[79:73] !== 7'd0)
                begin
                    $error("tdata padding: expected 0, got %0h", m_axis_tdata[79:73]);
                    err_count++;
                end
                if (m_axis_tuser !== head_run.status)
                begin
                    $error("status: expected %0d, got %0d", head_run.status, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tlast !== head_run.finished)
                begin
                    $error("finished: expected %0b, got %0b",
                           head_run.finished, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_seen != hold_token)
        begin
            hold_seen     <= hold_token;
            hold_left     <= LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d runs outstanding",
                     cycle_count, pending_runs.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Offer one byte, with random idle cycles first, and wait for the
    // transaction to complete. Called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic typed, input run_t r);
        byte_tag_t t;
        t.typed = typed;
        t.run   = r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        offered_tags.push_back(t);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Stop offering bytes and let the block run dry.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // One APB transfer: setup phase, access phase, then the bus is left idle.
    task automatic apb_access(input logic [2:0] addr, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write a register, then read the entry count back.
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] readback;
        apb_access(addr, 1'b1, value, readback);
        if (addr == ADDR_ENTRY_COUNT)
            entry_limit = value;
        cfg_writes++;
        apb_access(ADDR_ENTRY_COUNT, 1'b0, 32'd0, readback);
        if (readback !== entry_limit)
        begin
            $error("entry_count readback: expected %0h, got %0h", entry_limit, readback);
            err_count++;
        end
    endtask

    // Send one varint count, sized against the entries still to cover.
    task automatic send_count();
        logic [32:0] left;
        logic [31:0] cnt;
        logic [31:0] grp;
        int unsigned pick;
        int          groups;
        int          g;
        left = entries_left();
        pick = $urandom_range(99);
        if (left == 0)
            cnt = $urandom_range(3);
        else if (pick < 20)
            cnt = left[31:0] - 32'd1;
        else if (pick < 25)
            cnt = left[31:0] + $urandom_range(2);
        else if (pick < 30)
            cnt = $urandom;
        else if (left > 16)
            cnt = $urandom_range(15);
        else
            cnt = $urandom_range(left[31:0] - 32'd1);

        pick = $urandom_range(99);
        if (pick < 5)
        begin
            // Six groups: the accumulator wraps past 32 bits
            repeat (5) send_byte({1'b1, 7'($urandom_range(127))}, 1'b0, '0);
            send_byte({1'b0, 7'($urandom_range(127))}, 1'b0, '0);
        end
        else
        begin
            groups = 1;
            while (groups < 5 && (cnt >> (GROUP_BITS * groups)) != 0)
                groups++;
            // Now and then a redundant leading zero group
            if (pick < 15)
                send_byte({1'b1, 7'd0}, 1'b0, '0);
            for (g = groups - 1; g >= 0; g--)
            begin
                grp = cnt >> (GROUP_BITS * g);
                send_byte({(g != 0), grp[GROUP_BITS-1:0]}, 1'b0, '0);
            end
        end
    endtask

    // Next piece of a mostly well-formed stream, steered by the tracked phase.
    task automatic feed_stream_step();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6)
            send_byte(8'($urandom_range(255)), 1'b0, '0);
        else
        begin
            case (dec_phase)
                PH_HEADER:
                begin
                    pick = $urandom_range(99);
                    if (pick < 30)
                        send_byte(HDR_RAW, 1'b0, '0);
                    else if (pick < 60)
                        send_byte(HDR_PAIR, 1'b0, '0);
                    else if (pick < 90)
                        send_byte(HDR_ALT, 1'b0, '0);
                    else if (pick < 95)
                        send_byte(HDR_ABSENT, 1'b0, '0);
                    else
                        send_byte(8'($urandom_range(255, HDR_ABSENT + 1)), 1'b0, '0);
                end
                PH_PAIR_CNT, PH_ALT_CNT:
                    send_count();
                default:
                    send_byte(8'($urandom_range(255)), 1'b0, '0);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic void plan_byte(input logic [7:0] b);
        row_t r;
        r       = '0;
        r.kind  = ROW_BYTE;
        r.word  = {24'd0, b};
        plan.push_back(r);
    endfunction

    function automatic void plan_known(input logic [7:0] b, input logic [7:0] value,
                                       input logic [31:0] start, input logic [32:0] len,
                                       input logic [1:0] status, input logic fin);
        row_t r;
        r              = '0;
        r.kind         = ROW_BYTE;
        r.word         = {24'd0, b};
        r.typed        = 1'b1;
        r.run.value    = value;
        r.run.start    = start;
        r.run.length   = len;
        r.run.status   = status;
        r.run.finished = fin;
        plan.push_back(r);
    endfunction

    function automatic void plan_write(input row_kind_t kind, input logic [31:0] value);
        row_t r;
        r      = '0;
        r.kind = kind;
        r.word = value;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          phase_idx;
        int          seg;
        int          byte_goal;
        int unsigned pick;
        logic [31:0] count_value;

        // Straight after reset the count is one
        plan_known(HDR_ABSENT, 8'h00, 32'd0, 33'd0, ST_ABSENT, 1'b1);
        plan_known(8'hFF, 8'h00, 32'd0, 33'd0, ST_BADHEAD, 1'b1);
        plan_known(8'h04, 8'h00, 32'd0, 33'd0, ST_BADHEAD, 1'b1);
        plan_byte(HDR_RAW);
        plan_known(8'hAB, 8'hAB, 32'd0, 33'd1, ST_OK, 1'b1);
        // Largest count against the longest run: one past the count
        plan_write(ROW_COUNT_WRITE, 32'hFFFF_FFFF);
        plan_byte(HDR_PAIR);
        plan_byte(8'h00);
        plan_byte(8'h8F);
        plan_byte(8'hFF);
        plan_byte(8'hFF);
        plan_byte(8'hFF);
        plan_known(8'h7F, 8'h00, 32'd0, 33'h1_0000_0000, ST_OVER, 1'b1);
        // Alternating values, a one-byte count, then a two-byte count that overshoots
        plan_write(ROW_COUNT_WRITE, 32'd10);
        plan_byte(HDR_ALT);
        plan_byte(8'h11);
        plan_byte(8'hEE);
        plan_byte(8'h02);
        plan_byte(8'h81);
        plan_byte(8'h00);
        // Raw stream left mid-way, a write to the unused slot, then the
        // count dropped to zero beneath the current position
        plan_byte(HDR_RAW);
        plan_byte(8'h55);
        plan_write(ROW_SPARE_WRITE, 32'd0);
        plan_write(ROW_COUNT_WRITE, 32'd0);
        plan_byte(8'h7F);
        // A single pair that lands exactly on the count
        plan_write(ROW_COUNT_WRITE, 32'd5);
        plan_byte(HDR_PAIR);
        plan_byte(8'hC3);
        plan_byte(8'h04);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_BYTE:
                    send_byte(plan[i].word[7:0], plan[i].typed, plan[i].run);
                ROW_COUNT_WRITE:
                begin
                    settle_block();
                    cfg_write(ADDR_ENTRY_COUNT, plan[i].word);
                end
                default:
                begin
                    settle_block();
                    cfg_write(ADDR_SPARE, plan[i].word);
                end
            endcase
        end

        // Random streams under four flow-control settings
        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                end
            endcase
            for (seg = 0; seg < 4; seg++)
            begin
                settle_block();
                pick = $urandom_range(99);
                if (phase_idx == 0 && seg == 0)
                    count_value = 32'd40;
                else if (pick < 5)
                    count_value = 32'd1;
                else if (pick < 10)
                    count_value = 32'hFFFF_FFFF;
                else if (pick < 13)
                    count_value = 32'd0;
                else if (pick < 20)
                    count_value = $urandom;
                else
                    count_value = $urandom_range(48, 2);
                cfg_write(ADDR_ENTRY_COUNT, count_value);
                // Long receiver hold-off while bytes keep coming, to back
                // the block up until it refuses input
                if (phase_idx == 0 && seg == 0)
                    hold_token++;
                byte_goal = bytes_sent + SEGMENT_BYTES;
                while (bytes_sent < byte_goal)
                    feed_stream_step();
            end
        end

        settle_block();
        $display("Covered %0d stream bytes and %0d register writes; %0d runs checked",
                 bytes_sent, cfg_writes, runs_checked);
        $display("Run statuses: ok %0d, bad header %0d, past count %0d, absent %0d",
                 status_seen[ST_OK], status_seen[ST_BADHEAD],
                 status_seen[ST_OVER], status_seen[ST_ABSENT]);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
